@@ rtl/core/seg3_pkg.sv @@
package seg3_pkg;

   localparam int unsigned NUM_DIGITS = 3;
   localparam logic [2:0] PHASE_LAST = 3'd5;

   localparam logic [7:0] SEG_BLANK = 8'h00;
   localparam logic [7:0] SEG_MINUS = 8'h02;
   localparam logic [7:0] SEG_G_MASK = 8'h02;
   localparam logic [7:0] SEG_DRIVE_MASK = 8'hFE;
   localparam logic [2:0] SELECT_NONE = 3'd7;

   localparam logic [7:0] OFF_TICKS_RESET = 8'd2;
   localparam logic [7:0] ON_TICKS_RESET = 8'd10;

   // register indexes on the csr port
   localparam logic CSR_OFF_TICKS = 1'b0;
   localparam logic CSR_ON_TICKS = 1'b1;

   // item commands
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef struct packed {
      logic load;
      logic [NUM_DIGITS-1:0][7:0] pattern;
   } decode_type;

   function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
      logic [7:0] glyph;
      case (digit)
         4'd0: glyph = 8'hFC;
         4'd1: glyph = 8'h60;
         4'd2: glyph = 8'hDA;
         4'd3: glyph = 8'hF2;
         4'd4: glyph = 8'h66;
         4'd5: glyph = 8'hB6;
         4'd6: glyph = 8'hBE;
         4'd7: glyph = 8'hE4;
         4'd8: glyph = 8'hFE;
         4'd9: glyph = 8'hF6;
         default: glyph = SEG_BLANK;
      endcase
      return glyph;
   endfunction

   function automatic logic [2:0] select_code(input logic [1:0] digit);
      logic [2:0] code;
      case (digit)
         2'd0: code = 3'd6;
         2'd1: code = 3'd5;
         2'd2: code = 3'd3;
         default: code = SELECT_NONE;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/core/seven_segment_three_digit_scanner.sv @@
// Three-digit multiplexed seven-segment driver. Each accepted item gives exactly
// one result item in the next cycle, and a new item is taken every cycle while
// the result register is free or being drained, so the rate is one item per
// clock; the single result register is what sets it. A load item (cmd 1)
// decodes a signed value into three digit patterns: 0..999 shows with leading
// zeros blanked, values above 999 show as 999, -99..-1 shows a minus sign and
// two digits, and -100 or below is ignored. A load does not change the driven
// lines; its result repeats them. A scan tick item (cmd 0) steps a six-phase
// scan: blank gap, digit 0, gap, digit 1, gap, digit 2. A gap lasts
// off_ticks+1 ticks and clears segments a..f while keeping g and the select;
// a digit lasts on_ticks+1 ticks with its active-low select. scan_phase gives
// the phase that drove the lines of that tick. off_ticks sits at byte address
// 0 and on_ticks at 4 on the csr port; write them only while the block idles.
module seven_segment_three_digit_scanner
   import seg3_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic signed [10:0] req_value,
   // result items
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_seg_pattern,
   output logic [2:0]        rsp_digit_select,
   output logic [2:0]        rsp_scan_phase,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // config registers
   logic [7:0] off_ticks_ff;
   logic [7:0] on_ticks_ff;

   // scan state
   logic [NUM_DIGITS-1:0][7:0] pattern_ff, pattern_in;
   logic [2:0] phase_ff, phase_in;
   logic [8:0] count_ff, count_in;
   logic [7:0] seg_ff, seg_in;
   logic [2:0] sel_ff, sel_in;

   // result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_seg_ff;
   logic [2:0] rsp_sel_ff;
   logic [2:0] rsp_phase_ff;

   logic       accept;
   logic       csr_write;
   logic       csr_index;
   logic [8:0] count_inc;
   logic [1:0] digit;
   decode_type decode;

   seg3_decode u_decode (
      .value  (req_value),
      .decode (decode)
   );

   // result slot is free or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_seg_pattern = rsp_seg_ff;
   assign rsp_digit_select = rsp_sel_ff;
   assign rsp_scan_phase = rsp_phase_ff;

   // csr port, always ready, word index from address bit 2
   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {24'd0, (csr_index == CSR_ON_TICKS) ? on_ticks_ff : off_ticks_ff};

   // odd phases drive digit (phase-1)/2
   assign digit = phase_ff[2:1];
   assign count_inc = count_ff + 9'd1;

   always_comb begin
      pattern_in = pattern_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      seg_in = seg_ff;
      sel_in = sel_ff;
      if (req_cmd == CMD_LOAD) begin
         // new patterns, driven lines untouched
         if (decode.load) begin
            pattern_in = decode.pattern;
         end
      end else if (!phase_ff[0]) begin
         // blank gap: only g survives
         seg_in = seg_ff & SEG_G_MASK;
         count_in = count_inc;
         if (count_inc > {1'b0, off_ticks_ff}) begin
            phase_in = phase_ff + 3'd1;
            count_in = 9'd0;
         end
      end else begin
         // digit on phase
         seg_in = pattern_ff[digit] & SEG_DRIVE_MASK;
         sel_in = select_code(digit);
         count_in = count_inc;
         if (count_inc > {1'b0, on_ticks_ff}) begin
            phase_in = (phase_ff == PHASE_LAST) ? 3'd0 : phase_ff + 3'd1;
            count_in = 9'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ticks_ff <= OFF_TICKS_RESET;
         on_ticks_ff <= ON_TICKS_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_OFF_TICKS) begin
            off_ticks_ff <= csr_pwdata[7:0];
         end else begin
            on_ticks_ff <= csr_pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= {NUM_DIGITS{SEG_BLANK}};
         phase_ff <= 3'd0;
         count_ff <= 9'd0;
         seg_ff <= SEG_BLANK;
         sel_ff <= SELECT_NONE;
      end else if (accept) begin
         pattern_ff <= pattern_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         seg_ff <= seg_in;
         sel_ff <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_seg_ff <= seg_in;
         rsp_sel_ff <= sel_in;
         rsp_phase_ff <= phase_ff;
      end
   end

   // the scan never leaves its six phases
   assert property (@(posedge clock) disable iff (reset) phase_ff <= PHASE_LAST)
      else $error("scan phase out of range");

   // a tick in a blank gap drives segments a..f low
   assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_TICK && !phase_ff[0] |=> rsp_seg_pattern[7:2] == 6'd0)
      else $error("segments driven during blank gap");

   // at most one digit selected, segment bit 0 never driven
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(~rsp_digit_select) <= 1 && !rsp_seg_pattern[0])
      else $error("bad result lines");

   // a load leaves the scan position alone
   assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_LOAD |=> phase_ff == $past(phase_ff)
         && count_ff == $past(count_ff))
      else $error("load moved the scan");

endmodule

@@ rtl/core/seg3_decode.sv @@
module seg3_decode
   import seg3_pkg::*;
(
   input  logic signed [10:0] value,
   output decode_type         decode
);

   logic        neg;
   logic [9:0]  pos_sat;
   logic [15:0] hund_prod;
   logic [3:0]  hund;
   logic [9:0]  pos_rem;
   logic [10:0] neg_full;
   logic [6:0]  rem;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [6:0]  units_wide;
   logic [3:0]  units;

   always_comb begin
      neg = value[10];
      // clamp above 999
      pos_sat = (value[9:0] > 10'd999) ? 10'd999 : value[9:0];
      // n / 100 by reciprocal, exact for n below 1000
      hund_prod = 16'(pos_sat) * 16'd41;
      hund = hund_prod[15:12];
      pos_rem = pos_sat - 10'(hund) * 10'd100;
      neg_full = -value;
      rem = neg ? neg_full[6:0] : pos_rem[6:0];
      // r / 10 by reciprocal, exact for r below 100
      tens_prod = 15'(rem) * 15'd205;
      tens = tens_prod[14:11];
      units_wide = rem - 7'(tens) * 7'd10;
      units = units_wide[3:0];

      decode.load = !neg || (value > -11'sd100);
      decode.pattern[2] = digit_glyph(units);
      if (neg) begin
         decode.pattern[0] = SEG_MINUS;
         decode.pattern[1] = (tens == 4'd0) ? SEG_BLANK : digit_glyph(tens);
      end else begin
         decode.pattern[0] = (hund == 4'd0) ? SEG_BLANK : digit_glyph(hund);
         decode.pattern[1] = (hund == 4'd0 && tens == 4'd0) ? SEG_BLANK
                                                            : digit_glyph(tens);
      end
   end

endmodule

@@ verif/seven_segment_three_digit_scanner_test.sv @@
import seg3_pkg::*;

typedef struct packed {
   logic [7:0] seg;
   logic [2:0] sel;
   logic [2:0] phase;
} display_lines_type;

class segment_scoreboard;
   logic [7:0] off_ticks;
   logic [7:0] on_ticks;
   logic [7:0] digit_pattern [3];
   logic [2:0] scan_ph;
   logic [8:0] tick_count;
   logic [7:0] seg_hold;
   logic [2:0] select_hold;
   logic [7:0] glyph [10];
   logic [2:0] select_of [3];
   display_lines_type expected_lines [$];
   int n_loads;
   int n_ticks;
   int n_checked;
   int n_errors;

   function new();
      glyph = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE4, 8'hFE, 8'hF6};
      select_of = '{3'd6, 3'd5, 3'd3};
      off_ticks = OFF_TICKS_RESET;
      on_ticks = ON_TICKS_RESET;
      digit_pattern = '{SEG_BLANK, SEG_BLANK, SEG_BLANK};
      scan_ph = 3'd0;
      tick_count = 9'd0;
      seg_hold = SEG_BLANK;
      select_hold = SELECT_NONE;
      n_loads = 0;
      n_ticks = 0;
      n_checked = 0;
      n_errors = 0;
   endfunction

   function void set_timing(logic csr_index, logic [7:0] val);
      if (csr_index == CSR_OFF_TICKS) begin
         off_ticks = val;
      end else begin
         on_ticks = val;
      end
   endfunction

   // binary to decimal with leading-zero blanking
   function void decode_value(int v);
      int n;
      int h;
      int t;
      int u;
      if (v <= -100) begin
         return;
      end
      if (v >= 0) begin
         n = (v > 999) ? 999 : v;
         h = n / 100;
         t = (n / 10) % 10;
         u = n % 10;
         digit_pattern[0] = (h == 0) ? SEG_BLANK : glyph[h];
         digit_pattern[1] = (h == 0 && t == 0) ? SEG_BLANK : glyph[t];
         digit_pattern[2] = glyph[u];
      end else begin
         n = -v;
         t = n / 10;
         u = n % 10;
         digit_pattern[0] = SEG_MINUS;
         digit_pattern[1] = (t == 0) ? SEG_BLANK : glyph[t];
         digit_pattern[2] = glyph[u];
      end
   endfunction

   function void scan_step();
      logic [2:0] p;
      logic [1:0] d;
      p = (scan_ph > PHASE_LAST) ? 3'd0 : scan_ph;
      tick_count = tick_count + 9'd1;
      if (!p[0]) begin
         // gap: a..f dark, g and select keep their level
         seg_hold = seg_hold & SEG_G_MASK;
         if (tick_count > {1'b0, off_ticks}) begin
            scan_ph = p + 3'd1;
            tick_count = 9'd0;
         end
      end else begin
         d = p[2:1];
         seg_hold = digit_pattern[d] & SEG_DRIVE_MASK;
         select_hold = select_of[d];
         if (tick_count > {1'b0, on_ticks}) begin
            scan_ph = (p == PHASE_LAST) ? 3'd0 : p + 3'd1;
            tick_count = 9'd0;
         end
      end
   endfunction

   function void note_item(logic cmd, logic signed [10:0] value);
      display_lines_type e;
      e.phase = (scan_ph > PHASE_LAST) ? 3'd0 : scan_ph;
      if (cmd == CMD_LOAD) begin
         decode_value(value);
         n_loads++;
      end else begin
         scan_step();
         n_ticks++;
      end
      e.seg = seg_hold & SEG_DRIVE_MASK;
      e.sel = select_hold;
      expected_lines.push_back(e);
   endfunction

   function void check_lines(logic [7:0] seg, logic [2:0] sel, logic [2:0] phase);
      display_lines_type e;
      if (expected_lines.size() == 0) begin
         n_errors++;
         $display("%0t: unexpected result item seg %h sel %h phase %0d",
                  $time, seg, sel, phase);
         return;
      end
      e = expected_lines.pop_front();
      n_checked++;
      if (seg !== e.seg || sel !== e.sel || phase !== e.phase) begin
         n_errors++;
         $display("%0t: mismatch expected seg %h sel %h phase %0d, got seg %h sel %h phase %0d",
                  $time, e.seg, e.sel, e.phase, seg, sel, phase);
      end
   endfunction

   function int pending();
      return expected_lines.size();
   endfunction
endclass

module seven_segment_three_digit_scanner_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = CMD_TICK;
   logic signed [10:0] req_value = '0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_seg_pattern;
   logic [2:0] rsp_digit_select;
   logic [2:0] rsp_scan_phase;

   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // handshake idling mix, percent of cycles
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   // set by the stimulus, consumed by the receiver process
   bit hold_request = 1'b0;
   int idle_cycles = 0;
   int settings_used = 0;

   segment_scoreboard sb = new();

   seven_segment_three_digit_scanner u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_seg_pattern  (rsp_seg_pattern),
      .rsp_digit_select (rsp_digit_select),
      .rsp_scan_phase   (rsp_scan_phase),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   // both channels sampled on the edge, before the design's flops update
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_lines(rsp_seg_pattern, rsp_digit_select, rsp_scan_phase);
         end
         if (req_valid && req_ready) begin
            sb.note_item(req_cmd, req_value);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
         $display("seven_segment_three_digit_scanner_test: errors");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // setup cycle, access cycle, then a quiet cycle
   task automatic csr_write(input logic csr_index, input logic [7:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {csr_index, 2'b00};
      csr_pwdata <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_timing(csr_index, val);
      @(posedge clock);
   endtask

   task automatic csr_read(input logic csr_index, output logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {csr_index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      data = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_timing_regs();
      logic [31:0] rd;
      csr_read(CSR_OFF_TICKS, rd);
      if (rd[7:0] !== sb.off_ticks) begin
         sb.n_errors++;
         $display("%0t: off_ticks readback expected %0d, got %0d", $time, sb.off_ticks, rd[7:0]);
      end
      csr_read(CSR_ON_TICKS, rd);
      if (rd[7:0] !== sb.on_ticks) begin
         sb.n_errors++;
         $display("%0t: on_ticks readback expected %0d, got %0d", $time, sb.on_ticks, rd[7:0]);
      end
   endtask

   // only called with the block drained
   task automatic program_timing(input logic [7:0] off_val, input logic [7:0] on_val);
      csr_write(CSR_OFF_TICKS, off_val);
      csr_write(CSR_ON_TICKS, on_val);
      check_timing_regs();
      settings_used++;
   endtask

   // offer one item, return on the edge that accepts it
   task automatic send_item(input logic cmd, input logic signed [10:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sender stops until every predicted result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the monitor note the item taken on the last edge
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_then_scan(input int v);
      send_item(CMD_LOAD, v[10:0]);
      send_item(CMD_TICK, 11'($urandom));
      send_item(CMD_TICK, 11'($urandom));
   endtask

   task automatic random_items(input int count, input int tick_pct);
      int sel;
      int v;
      logic cmd;
      for (int i = 0; i < count; i++) begin
         v = $urandom_range(2047);
         cmd = CMD_TICK;
         if ($urandom_range(99) >= tick_pct) begin
            cmd = CMD_LOAD;
            sel = $urandom_range(99);
            if (sel < 35) begin
               v = $urandom_range(999);
            end else if (sel < 45) begin
               v = $urandom_range(1023, 1000);
            end else if (sel < 70) begin
               v = $urandom_range(99, 1);
               v = -v;
            end else if (sel < 80) begin
               v = $urandom_range(1024, 100);
               v = -v;
            end
            // otherwise any 11-bit pattern
         end
         send_item(cmd, v[10:0]);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the timing registers
      check_timing_regs();

      // directed: one-tick phases so the scan walks quickly over each display
      program_timing(8'd0, 8'd0);
      load_then_scan(0);
      load_then_scan(10);
      load_then_scan(105);
      load_then_scan(999);
      load_then_scan(1023);
      load_then_scan(-7);
      load_then_scan(-99);
      load_then_scan(-100);
      load_then_scan(-1024);
      wait_drained();

      // no idling
      program_timing(8'd3, 8'd7);
      random_items(140, 75);
      wait_drained();

      // sender idles
      sender_idle_pct = 58;
      program_timing(8'd1, 8'd2);
      random_items(140, 75);
      wait_drained();

      // receiver stalls
      sender_idle_pct = 0;
      receiver_stall_pct = 58;
      program_timing(8'd6, 8'd1);
      random_items(140, 75);
      wait_drained();

      // both idle, longest phases, tick heavy so the first gap runs out
      sender_idle_pct = 36;
      receiver_stall_pct = 36;
      program_timing(8'd255, 8'd255);
      random_items(320, 95);
      wait_drained();

      // shortest phases mid-count, then a long output hold while items keep coming
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      program_timing(8'd0, 8'd0);
      hold_request = 1'b1;
      random_items(60, 70);
      wait_drained();

      $display("%0d loads and %0d scan ticks predicted, %0d result items checked, %0d mismatches",
               sb.n_loads, sb.n_ticks, sb.n_checked, sb.n_errors);
      $display("%0d timing settings from 1 to 256 ticks per phase, four idling mixes, one long hold",
               settings_used);
      if (sb.n_errors == 0 && sb.pending() == 0) begin
         $display("seven_segment_three_digit_scanner_test: clean");
      end else begin
         $display("seven_segment_three_digit_scanner_test: errors");
      end
      $finish;
   end

endmodule
